/* hdl/hsvsk_pkg.sv */
// Package for the HSV skin mask gray block: shared types, constants and the
// divider step function. It has no dependencies of its own.
package hsvsk_pkg;

   // Field widths fixed by the pixel format.
   localparam int ChanWidth    = 8;
   localparam int NumWidth     = 17;
   localparam int DenWidth     = 9;
   localparam int QuotWidth    = 8;
   localparam int DivStages    = 4;
   localparam int BitsPerStage = QuotWidth / DivStages;
   localparam int ProdWidth    = 24;
   localparam int CsrIdxWidth  = 3;

   // Q16 luma weights for 0.299, 0.587 and 0.114.
   localparam logic [15:0] LumaRQ16 = 16'd19595;
   localparam logic [15:0] LumaGQ16 = 16'd38470;
   localparam logic [15:0] LumaBQ16 = 16'd7471;

   // Scale factors for the saturation and hue numerators.
   localparam logic [9:0] SatScale  = 10'd510;
   localparam logic [7:0] HueSlope  = 8'd30;
   localparam logic [7:0] HueWrap   = 8'd180;
   localparam logic [6:0] HueBaseR  = 7'd0;
   localparam logic [6:0] HueBaseG  = 7'd60;
   localparam logic [6:0] HueBaseB  = 7'd120;

   // Register reset values.
   localparam logic [7:0] HueLowReset  = 8'd0;
   localparam logic [7:0] HueHighReset = 8'd62;
   localparam logic [7:0] SatLowReset  = 8'd34;
   localparam logic [7:0] SatHighReset = 8'd195;
   localparam logic [7:0] ValLowReset  = 8'd72;
   localparam logic [7:0] ValHighReset = 8'd185;

   // Configuration register indexes.
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_HUE_LOW  = 3'd0,
      CSR_HUE_HIGH = 3'd1,
      CSR_SAT_LOW  = 3'd2,
      CSR_SAT_HIGH = 3'd3,
      CSR_VAL_LOW  = 3'd4,
      CSR_VAL_HIGH = 3'd5
   } csr_index_type;

   // Which channel holds the maximum; ties go red, then green.
   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } hue_sect_type;

   typedef struct packed {
      logic [7:0] blue_in;
      logic [7:0] green_in;
      logic [7:0] red_in;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0] gray_out;
      logic       in_window;
      logic       frame_end_out;
   } rsp_type;

   typedef struct packed {
      logic [7:0] hue_low;
      logic [7:0] hue_high;
      logic [7:0] sat_low;
      logic [7:0] sat_high;
      logic [7:0] val_low;
      logic [7:0] val_high;
   } thresh_type;

   // Values that ride alongside the divisions.
   typedef struct packed {
      logic [7:0] val;
      logic [7:0] gray;
      logic       frame_end;
   } side_type;

   // First front stage: extremes, hue sector and luma products.
   typedef struct packed {
      logic [7:0]           val;
      logic [7:0]           delta;
      logic signed [8:0]    hue_diff;
      hue_sect_type         sect;
      logic [ProdWidth-1:0] prod_r;
      logic [ProdWidth-1:0] prod_g;
      logic [ProdWidth-1:0] prod_b;
      logic                 frame_end;
   } stage1_type;

   // One division in flight: partial remainder, divisor, quotient so far.
   typedef struct packed {
      logic [NumWidth-1:0]  rem;
      logic [DenWidth-1:0]  den;
      logic [QuotWidth-1:0] quot;
   } div_lane_type;

   // Front end output: both divisions set up, plus side values.
   typedef struct packed {
      div_lane_type sat;
      div_lane_type hue;
      side_type     side;
   } front_type;

   // Divider output handed to the window test.
   typedef struct packed {
      logic [7:0] sat;
      logic [7:0] hue;
      side_type   side;
   } quot_type;

   // Restoring division over the quotient bits owned by one stage.
   function automatic div_lane_type div_pass(div_lane_type lane, int stage);
      div_lane_type        res;
      logic [NumWidth-1:0] den_sh;
      int                  sh;
      res = lane;
      for (int j = 0; j < BitsPerStage; j++) begin
         sh = QuotWidth - 1 - stage * BitsPerStage - j;
         den_sh = NumWidth'(res.den) << sh;
         if (res.rem >= den_sh) begin
            res.rem = res.rem - den_sh;
            res.quot[3'(sh)] = 1'b1;
         end
      end
      return res;
   endfunction

endpackage

/* hdl/hsvsk_front.sv */
// Front end of the HSV skin mask pipeline: max/min, hue sector, division
// operands and luma, over two register stages. Depends on hsvsk_pkg.
module hsvsk_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  hsvsk_pkg::req_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output hsvsk_pkg::front_type out_data
);
   import hsvsk_pkg::*;

   stage1_type s1_in, s1_ff;
   front_type  s2_in, s2_ff;
   logic       s1_valid_ff, s2_valid_ff;
   logic       adv1, adv2;

   // A stage advances when it is empty or the next one advances.
   assign adv2     = !s2_valid_ff || out_ready;
   assign adv1     = !s1_valid_ff || adv2;
   assign in_ready = adv1;

   // Stage 1: channel maximum and minimum, hue sector and luma products.
   always_comb begin
      logic [7:0] b, g, r, mn;
      b = in_data.blue_in;
      g = in_data.green_in;
      r = in_data.red_in;
      s1_in.val = r;
      if (g > s1_in.val) s1_in.val = g;
      if (b > s1_in.val) s1_in.val = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      s1_in.delta = s1_in.val - mn;
      if (s1_in.val == r) begin
         s1_in.sect     = SECT_RED;
         s1_in.hue_diff = $signed({1'b0, g}) - $signed({1'b0, b});
      end else if (s1_in.val == g) begin
         s1_in.sect     = SECT_GREEN;
         s1_in.hue_diff = $signed({1'b0, b}) - $signed({1'b0, r});
      end else begin
         s1_in.sect     = SECT_BLUE;
         s1_in.hue_diff = $signed({1'b0, r}) - $signed({1'b0, g});
      end
      s1_in.prod_r    = ProdWidth'(LumaRQ16) * ProdWidth'(r);
      s1_in.prod_g    = ProdWidth'(LumaGQ16) * ProdWidth'(g);
      s1_in.prod_b    = ProdWidth'(LumaBQ16) * ProdWidth'(b);
      s1_in.frame_end = in_data.frame_end;
   end

   // Stage 2: numerators and divisors for saturation and hue, luma sum.
   always_comb begin
      logic [6:0]         base;
      logic [14:0]        base_d;
      logic [15:0]        wrap_d;
      logic signed [17:0] t;
      logic [ProdWidth:0] luma_sum;
      case (s1_ff.sect)
         SECT_RED:   base = HueBaseR;
         SECT_GREEN: base = HueBaseG;
         SECT_BLUE:  base = HueBaseB;
         default:    base = HueBaseR;
      endcase
      base_d = 15'(base) * 15'(s1_ff.delta);
      wrap_d = 16'(HueWrap) * 16'(s1_ff.delta);
      t = 18'sd30 * 18'(s1_ff.hue_diff) + $signed({3'b000, base_d});
      if (t < 0) t = t + $signed({2'b00, wrap_d});

      s2_in.hue.rem  = {t[15:0], 1'b0} + NumWidth'(s1_ff.delta);
      s2_in.hue.den  = (s1_ff.delta == 8'd0) ? DenWidth'(1) : {s1_ff.delta, 1'b0};
      s2_in.hue.quot = '0;

      s2_in.sat.rem  = NumWidth'(NumWidth'(SatScale) * NumWidth'(s1_ff.delta))
                       + NumWidth'(s1_ff.val);
      s2_in.sat.den  = (s1_ff.val == 8'd0) ? DenWidth'(2) : {s1_ff.val, 1'b0};
      s2_in.sat.quot = '0;

      luma_sum = (ProdWidth+1)'(s1_ff.prod_r) + (ProdWidth+1)'(s1_ff.prod_g)
                 + (ProdWidth+1)'(s1_ff.prod_b);
      s2_in.side.val       = s1_ff.val;
      s2_in.side.gray      = luma_sum[23:16];
      s2_in.side.frame_end = s1_ff.frame_end;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= in_valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv1) s1_ff <= s1_in;
      if (adv2) s2_ff <= s2_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

endmodule

/* hdl/hsvsk_div_pipe.sv */
// Pipelined restoring divider for saturation and hue, two quotient bits per
// stage on both lanes, with side values carried along. Depends on hsvsk_pkg.
module hsvsk_div_pipe (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hsvsk_pkg::front_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hsvsk_pkg::quot_type  out_data
);
   import hsvsk_pkg::*;

   div_lane_type sat_ff [DivStages];
   div_lane_type hue_ff [DivStages];
   side_type     side_ff[DivStages];
   logic         valid_ff[DivStages];
   logic         adv[DivStages+1];

   // Ready chain from the output back to the input.
   always_comb begin
      adv[DivStages] = out_ready;
      for (int k = DivStages - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end
   assign in_ready = adv[0];

   // Each stage resolves its quotient bits on both lanes.
   for (genvar k = 0; k < DivStages; k++) begin : g_stage
      div_lane_type sat_in, hue_in;
      side_type     side_in;
      logic         valid_in;

      if (k == 0) begin : g_first
         assign sat_in   = div_pass(in_data.sat, k);
         assign hue_in   = div_pass(in_data.hue, k);
         assign side_in  = in_data.side;
         assign valid_in = in_valid;
      end else begin : g_next
         assign sat_in   = div_pass(sat_ff[k-1], k);
         assign hue_in   = div_pass(hue_ff[k-1], k);
         assign side_in  = side_ff[k-1];
         assign valid_in = valid_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            sat_ff[k]  <= sat_in;
            hue_ff[k]  <= hue_in;
            side_ff[k] <= side_in;
         end
      end
   end

   assign out_valid     = valid_ff[DivStages-1];
   assign out_data.sat  = sat_ff[DivStages-1].quot;
   assign out_data.hue  = hue_ff[DivStages-1].quot;
   assign out_data.side = side_ff[DivStages-1];

endmodule

/* hdl/hsvsk_window.sv */
// Window test and output register of the HSV skin mask pipeline: compares
// H, S and V against the bounds and gates the luma. Depends on hsvsk_pkg.
module hsvsk_window (
   input  logic                  clock,
   input  logic                  reset,
   input  hsvsk_pkg::thresh_type bounds,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hsvsk_pkg::quot_type   in_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hsvsk_pkg::rsp_type    rsp_data
);
   import hsvsk_pkg::*;

   rsp_type rsp_in, rsp_ff;
   logic    rsp_valid_ff;
   logic    adv;

   // The output register takes a new transaction when empty or being taken.
   assign adv      = !rsp_valid_ff || !rsp_stall;
   assign in_ready = adv;

   // All bounds are exclusive on both sides.
   always_comb begin
      logic in_win;
      in_win = (in_data.hue > bounds.hue_low) && (in_data.hue < bounds.hue_high)
            && (in_data.sat > bounds.sat_low) && (in_data.sat < bounds.sat_high)
            && (in_data.side.val > bounds.val_low)
            && (in_data.side.val < bounds.val_high);
      rsp_in.gray_out      = in_win ? in_data.side.gray : 8'd0;
      rsp_in.in_window     = in_win;
      rsp_in.frame_end_out = in_data.side.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hdl/hsv_skin_mask_gray_core.sv */
// HSV skin mask gray core: converts each BGR pixel to 8-bit HSV, tests it
// against six exclusive bounds and emits the luma from Q16 weights or zero.
// Depends on hsvsk_pkg, hsvsk_front, hsvsk_div_pipe and hsvsk_window.
//
// The core accepts one pixel per clock while req_stall is low and returns
// one result transaction per pixel, in order, through seven register
// stages: two front stages for the extremes, division operands and luma,
// four divider stages that each resolve two quotient bits of saturation
// and hue, and the output register. The first stage loads at acceptance,
// and the result is offered once it reaches the output register. Every
// stage advances when it is empty or the stage after it advances, so a
// stall on the result side lets the pipeline fill before req_stall rises,
// and bubbles close up. The bound registers are written through the csr
// port, which is always ready; writes to indexes above five are dropped.
// Write them only while no pixel is in flight.
module hsv_skin_mask_gray_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  hsvsk_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hsvsk_pkg::rsp_type  rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [hsvsk_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [7:0]          csr_data
);
   import hsvsk_pkg::*;

   thresh_type bounds_ff;
   logic       front_ready, front_valid;
   front_type  front_data;
   logic       div_ready, div_valid;
   quot_type   div_data;
   logic       win_ready;

   assign csr_ready = 1'b1;

   // Bound registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bounds_ff.hue_low  <= HueLowReset;
         bounds_ff.hue_high <= HueHighReset;
         bounds_ff.sat_low  <= SatLowReset;
         bounds_ff.sat_high <= SatHighReset;
         bounds_ff.val_low  <= ValLowReset;
         bounds_ff.val_high <= ValHighReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HUE_LOW:  bounds_ff.hue_low  <= csr_data;
            CSR_HUE_HIGH: bounds_ff.hue_high <= csr_data;
            CSR_SAT_LOW:  bounds_ff.sat_low  <= csr_data;
            CSR_SAT_HIGH: bounds_ff.sat_high <= csr_data;
            CSR_VAL_LOW:  bounds_ff.val_low  <= csr_data;
            CSR_VAL_HIGH: bounds_ff.val_high <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_stall = !front_ready;

   // Pipeline sections.
   hsvsk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_ready (div_ready),
      .out_data  (front_data)
   );

   hsvsk_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (div_ready),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_ready (win_ready),
      .out_data  (div_data)
   );

   hsvsk_window u_window (
      .clock     (clock),
      .reset     (reset),
      .bounds    (bounds_ff),
      .in_valid  (div_valid),
      .in_ready  (win_ready),
      .in_data   (div_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
